// ----- rtl/pnd_pkg.sv -----
// Shared types and constants of the normal density evaluator.
`default_nettype none

package pnd_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int STD_W     = 15;
   localparam int DENSITY_W = 24;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_MEAN    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STD_DEV = 1'b1;

   localparam logic [SAMPLE_W-1:0] MEAN_RESET    = 16'd0;
   localparam logic [STD_W-1:0]    STD_DEV_RESET = 15'd256;

   // Q31 constants
   localparam logic [31:0] ONE_Q31          = 32'h8000_0000;
   localparam logic [63:0] HALF_Q31         = 64'h0000_0000_4000_0000;
   localparam logic [29:0] E1_Q31           = 30'd790015085;
   localparam logic [29:0] INV_SQRT_2PI_Q31 = 30'd856722024;

   localparam int SERIES_TERMS = 15;
   localparam int MAX_WHOLE    = 40;

   localparam logic [DENSITY_W-1:0] DENSITY_MAX = 24'hFF_FFFF;

   // Classified item handed from the front part to the back part
   typedef struct packed {
      logic             err;
      logic [STD_W-1:0] s;
      logic [31:0]      ad_sq;
      logic [29:0]      s_sq;
   } item_type;

endpackage

`default_nettype wire

// ----- rtl/pnd_fifo.sv -----
// Small first-word-fall-through queue.
`default_nettype none

module pnd_fifo #(
   parameter int W     = 8,
   parameter int DEPTH = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire logic [W-1:0] wdata,
   output logic              full,
   input  wire logic         pop,
   output logic [W-1:0]      rdata,
   output logic              empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [W-1:0]  mem [0:DEPTH-1];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/pnd_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`default_nettype none

module pnd_div #(
   parameter int NUM_W  = 47,
   parameter int DEN_W  = 30,
   parameter int QUO_W  = 22,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [NUM_W-1:0]  num,
   input  wire logic [DEN_W-1:0]  den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [QUO_W-1:0]       quo,
   output logic                   ovf,
   output logic [SIDE_W-1:0]      out_side
);

   localparam int CW = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

   logic              v_ff    [0:QUO_W];
   logic [NUM_W-1:0]  rem_ff  [0:QUO_W];
   logic [DEN_W-1:0]  den_ff  [0:QUO_W];
   logic [QUO_W-1:0]  quo_ff  [0:QUO_W];
   logic              ovf_ff  [0:QUO_W];
   logic [SIDE_W-1:0] side_ff [0:QUO_W];
   logic              ovf_in;

   // Quotient would not fit: flag it and let the bits run as they fall
   assign ovf_in = (CW'(num) >= (CW'(den) << QUO_W));

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= num;
         den_ff[0]  <= den;
         quo_ff[0]  <= '0;
         ovf_ff[0]  <= ovf_in;
         side_ff[0] <= in_side;
      end
   end

   for (genvar i = 0; i < QUO_W; i++) begin : g_stage
      localparam int B = QUO_W - 1 - i;
      logic [CW-1:0]    shifted;
      logic             ge;
      logic [NUM_W-1:0] rem_in;
      logic [QUO_W-1:0] quo_in;

      assign shifted = CW'(den_ff[i]) << B;
      assign ge      = (CW'(rem_ff[i]) >= shifted);
      assign rem_in  = ge ? NUM_W'(CW'(rem_ff[i]) - shifted) : rem_ff[i];
      assign quo_in  = ge ? (quo_ff[i] | (QUO_W'(1) << B)) : quo_ff[i];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en) begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i+1]  <= rem_in;
            den_ff[i+1]  <= den_ff[i];
            quo_ff[i+1]  <= quo_in;
            ovf_ff[i+1]  <= ovf_ff[i];
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid = v_ff[QUO_W];
   assign quo       = quo_ff[QUO_W];
   assign ovf       = ovf_ff[QUO_W];
   assign out_side  = side_ff[QUO_W];

endmodule

`default_nettype wire

// ----- rtl/pnd_front.sv -----
// Front part: takes samples, forms the offset from the mean and the squares.
`default_nettype none

module pnd_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire logic                         in_valid,
   input  wire logic [pnd_pkg::SAMPLE_W-1:0] sample,
   input  wire logic [pnd_pkg::SAMPLE_W-1:0] mean,
   input  wire logic [pnd_pkg::STD_W-1:0]    std_dev,
   output logic                              out_valid,
   output pnd_pkg::item_type                 out_item
);

   logic signed [16:0]          d_in;
   logic [16:0]                 mag_in;
   logic                        v1_ff, v2_ff;
   logic [15:0]                 ad_ff;
   logic [pnd_pkg::STD_W-1:0]   s_ff;
   logic                        err_ff;
   pnd_pkg::item_type           item_ff, item_in;

   assign d_in   = $signed({sample[15], sample}) - $signed({mean[15], mean});
   assign mag_in = d_in[16] ? 17'(17'd0 - 17'(d_in)) : 17'(d_in);

   always_comb begin
      item_in.err   = err_ff;
      item_in.s     = s_ff;
      item_in.ad_sq = 32'(ad_ff) * 32'(ad_ff);
      item_in.s_sq  = 30'(s_ff) * 30'(s_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ad_ff   <= mag_in[15:0];
         s_ff    <= std_dev;
         err_ff  <= (std_dev == '0);
         item_ff <= item_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

// ----- rtl/pnd_series.sv -----
// Pipelined Taylor series of exp(-f) in Q31, three stages per term.
`default_nettype none

module pnd_series #(
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [30:0]       f31,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [31:0]            e,
   output logic [SIDE_W-1:0]      out_side
);

   localparam int TERMS = pnd_pkg::SERIES_TERMS;

   logic               v_ff    [1:TERMS];
   logic [31:0]        t_ff    [1:TERMS];
   logic signed [33:0] sum_ff  [1:TERMS];
   logic [30:0]        f_ff    [1:TERMS];
   logic [SIDE_W-1:0]  side_ff [1:TERMS];

   for (genvar n = 1; n <= TERMS; n++) begin : g_term
      localparam logic [32:0] RECIP = 33'(64'h1_0000_0000 / n);
      localparam logic [35:0] N     = 36'(n);
      localparam bit          ODD   = (n % 2) == 1;

      logic               v_src;
      logic [31:0]        t_src;
      logic signed [33:0] sum_src;
      logic [30:0]        f_src;
      logic [SIDE_W-1:0]  side_src;

      logic               a_v_ff, b_v_ff;
      logic [31:0]        a_x_ff, b_x_ff, b_q_ff;
      logic signed [33:0] a_sum_ff, b_sum_ff;
      logic [30:0]        a_f_ff, b_f_ff;
      logic [SIDE_W-1:0]  a_side_ff, b_side_ff;

      logic [63:0]        prod_in;
      logic [64:0]        mq_in;
      logic [35:0]        r_in;
      logic [31:0]        q_in;
      logic signed [33:0] sum_in;

      if (n == 1) begin : g_first
         assign v_src    = in_valid;
         assign t_src    = pnd_pkg::ONE_Q31;
         assign sum_src  = 34'(pnd_pkg::ONE_Q31);
         assign f_src    = f31;
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = v_ff[n-1];
         assign t_src    = t_ff[n-1];
         assign sum_src  = sum_ff[n-1];
         assign f_src    = f_ff[n-1];
         assign side_src = side_ff[n-1];
      end

      // term * f in Q31, then floor division by n via reciprocal and one fix-up
      assign prod_in = 64'(t_src) * 64'(f_src);
      assign mq_in   = 65'(a_x_ff) * 65'(RECIP);
      assign r_in    = 36'(b_x_ff) - 36'(b_q_ff) * N;
      assign q_in    = (r_in >= N) ? b_q_ff + 32'd1 : b_q_ff;
      assign sum_in  = ODD ? b_sum_ff - $signed(34'(q_in)) : b_sum_ff + $signed(34'(q_in));

      always_ff @(posedge clock) begin
         if (reset) begin
            a_v_ff  <= 1'b0;
            b_v_ff  <= 1'b0;
            v_ff[n] <= 1'b0;
         end else if (en) begin
            a_v_ff  <= v_src;
            b_v_ff  <= a_v_ff;
            v_ff[n] <= b_v_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            a_x_ff     <= prod_in[62:31];
            a_sum_ff   <= sum_src;
            a_f_ff     <= f_src;
            a_side_ff  <= side_src;
            b_x_ff     <= a_x_ff;
            b_q_ff     <= mq_in[63:32];
            b_sum_ff   <= a_sum_ff;
            b_f_ff     <= a_f_ff;
            b_side_ff  <= a_side_ff;
            t_ff[n]    <= q_in;
            sum_ff[n]  <= sum_in;
            f_ff[n]    <= b_f_ff;
            side_ff[n] <= b_side_ff;
         end
      end
   end

   // Clamp the sum to [0, 1.0]
   always_comb begin
      if (sum_ff[TERMS][33]) begin
         e = '0;
      end else if (sum_ff[TERMS] > $signed(34'(pnd_pkg::ONE_Q31))) begin
         e = pnd_pkg::ONE_Q31;
      end else begin
         e = sum_ff[TERMS][31:0];
      end
   end

   assign out_valid = v_ff[TERMS];
   assign out_side  = side_ff[TERMS];

endmodule

`default_nettype wire

// ----- rtl/pnd_back.sv -----
// Back part: exponent division, exponential, scaling and final division.
`default_nettype none

module pnd_back #(
   parameter int FRAC_BITS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire pnd_pkg::item_type             in_item,
   output logic                               out_valid,
   output logic [pnd_pkg::DENSITY_W-1:0]      density,
   output logic                               sigma_error
);

   localparam int STD_W  = pnd_pkg::STD_W;
   localparam int MAXW   = pnd_pkg::MAX_WHOLE;
   localparam int NUM2_W = 31 + FRAC_BITS;

   // exponent magnitude q = ad^2 * 2^15 / s^2
   logic              d1_v;
   logic [21:0]       d1_q;
   logic              d1_ovf;
   logic [STD_W:0]    d1_side;

   pnd_div #(
      .NUM_W  (47),
      .DEN_W  (30),
      .QUO_W  (22),
      .SIDE_W (STD_W + 1)
   ) u_div_exp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_valid),
      .num       ({in_item.ad_sq, 15'd0}),
      .den       (in_item.s_sq),
      .in_side   ({in_item.err, in_item.s}),
      .out_valid (d1_v),
      .quo       (d1_q),
      .ovf       (d1_ovf),
      .out_side  (d1_side)
   );

   // Split into whole part and fraction, mark the far tail
   logic              kv_ff;
   logic [30:0]       f_ff;
   logic [5:0]        k_ff;
   logic              far_ff;
   logic [STD_W:0]    ks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kv_ff <= 1'b0;
      end else if (en) begin
         kv_ff <= d1_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_ff   <= {d1_q[15:0], 15'd0};
         k_ff   <= d1_q[21:16];
         far_ff <= d1_ovf || (d1_q[21:16] > 6'(MAXW));
         ks_ff  <= d1_side;
      end
   end

   localparam int SER_SIDE_W = 6 + 1 + STD_W + 1;

   logic                  sr_v;
   logic [31:0]           sr_e;
   logic [SER_SIDE_W-1:0] sr_side;

   pnd_series #(
      .SIDE_W (SER_SIDE_W)
   ) u_series (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (kv_ff),
      .f31       (f_ff),
      .in_side   ({k_ff, far_ff, ks_ff}),
      .out_valid (sr_v),
      .e         (sr_e),
      .out_side  (sr_side)
   );

   // Multiply by exp(-1) once per whole unit of the exponent
   logic           pw_v_ff [0:MAXW];
   logic [31:0]    pw_e_ff [0:MAXW];
   logic [5:0]     pw_k_ff [0:MAXW];
   logic [STD_W:0] pw_s_ff [0:MAXW];

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_v_ff[0] <= 1'b0;
      end else if (en) begin
         pw_v_ff[0] <= sr_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pw_e_ff[0] <= sr_side[STD_W+1] ? 32'd0 : sr_e;
         pw_k_ff[0] <= sr_side[SER_SIDE_W-1 -: 6];
         pw_s_ff[0] <= sr_side[STD_W:0];
      end
   end

   for (genvar j = 1; j <= MAXW; j++) begin : g_pow
      logic [63:0] prod_in;

      assign prod_in = 64'(pw_e_ff[j-1]) * 64'(pnd_pkg::E1_Q31) + pnd_pkg::HALF_Q31;

      always_ff @(posedge clock) begin
         if (reset) begin
            pw_v_ff[j] <= 1'b0;
         end else if (en) begin
            pw_v_ff[j] <= pw_v_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            pw_e_ff[j] <= (6'(j) <= pw_k_ff[j-1]) ? prod_in[62:31] : pw_e_ff[j-1];
            pw_k_ff[j] <= pw_k_ff[j-1];
            pw_s_ff[j] <= pw_s_ff[j-1];
         end
      end
   end

   // Scale by 1/sqrt(2*pi)
   logic           sc_v_ff;
   logic [29:0]    p_ff;
   logic [STD_W:0] sc_s_ff;
   logic [63:0]    p_in;

   assign p_in = 64'(pw_e_ff[MAXW]) * 64'(pnd_pkg::INV_SQRT_2PI_Q31) + pnd_pkg::HALF_Q31;

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_v_ff <= 1'b0;
      end else if (en) begin
         sc_v_ff <= pw_v_ff[MAXW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff    <= p_in[60:31];
         sc_s_ff <= pw_s_ff[MAXW];
      end
   end

   // Divide by sigma, rounding halves up
   logic [NUM2_W-1:0]              num2;
   logic                           d2_v;
   logic [pnd_pkg::DENSITY_W-1:0]  d2_q;
   logic                           d2_ovf;
   logic                           d2_err;

   assign num2 = (NUM2_W'(p_ff) << FRAC_BITS) + (NUM2_W'(sc_s_ff[STD_W-1:0]) << 14);

   pnd_div #(
      .NUM_W  (NUM2_W),
      .DEN_W  (30),
      .QUO_W  (pnd_pkg::DENSITY_W),
      .SIDE_W (1)
   ) u_div_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sc_v_ff),
      .num       (num2),
      .den       ({sc_s_ff[STD_W-1:0], 15'd0}),
      .in_side   (sc_s_ff[STD_W]),
      .out_valid (d2_v),
      .quo       (d2_q),
      .ovf       (d2_ovf),
      .out_side  (d2_err)
   );

   assign out_valid   = d2_v;
   assign sigma_error = d2_err;
   assign density     = d2_err ? '0 : (d2_ovf ? pnd_pkg::DENSITY_MAX : d2_q);

endmodule

`default_nettype wire

// ----- rtl/normal_pdf_evaluator.sv -----
// Top level of the normal probability density evaluator.
//
// Usage:
//   Samples (signed Q8.8) enter through a queue-style port: a transaction
//   completes when req_push is high and req_full is low. Results leave the
//   same way: the oldest result sits on rsp_density (unsigned Q8.16) and
//   rsp_sigma_error while rsp_empty is low, and is taken when rsp_pop is high.
//   mean (index 0) and std_dev (index 1) are written through csr_*, which is
//   always ready; write them only while no sample is in flight.
//   Throughput is one sample per cycle while req_full is low. Pipeline depth
//   is set by the two bit-serial division pipelines (22 and 24 stages),
//   the exp series (3 stages per term, 15 terms) and the 40 exp(-1) stages.
//   A zero std_dev yields density 0 with rsp_sigma_error set.
//   Reset clears both queues and all valid bits; registers return to mean 0,
//   std_dev 1.0. When the receiver stalls, the back pipeline holds once the
//   output queue fills, then the middle queue fills and req_full rises;
//   nothing is dropped.
`default_nettype none

module normal_pdf_evaluator #(
   parameter int FRAC_BITS = 8,
   parameter int MID_DEPTH = 4,
   parameter int OUT_DEPTH = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic [pnd_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic [pnd_pkg::DENSITY_W-1:0]      rsp_density,
   output logic                               rsp_sigma_error,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [pnd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [pnd_pkg::CSR_DAT_W-1:0] csr_wdata
);

   localparam int ITEM_W = $bits(pnd_pkg::item_type);
   localparam int OUT_W  = pnd_pkg::DENSITY_W + 1;

   // Configuration registers
   logic [pnd_pkg::SAMPLE_W-1:0] mean_ff;
   logic [pnd_pkg::STD_W-1:0]    std_dev_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff    <= pnd_pkg::MEAN_RESET;
         std_dev_ff <= pnd_pkg::STD_DEV_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pnd_pkg::CSR_MEAN: begin
               mean_ff <= csr_wdata;
            end
            pnd_pkg::CSR_STD_DEV: begin
               std_dev_ff <= csr_wdata[pnd_pkg::STD_W-1:0];
            end
            default: begin
               // drop writes to unknown registers
            end
         endcase
      end
   end

   // Front part: advance while the middle queue has room
   logic              mid_full, mid_empty;
   logic              front_en, front_v;
   pnd_pkg::item_type front_item;
   logic [ITEM_W-1:0] mid_rdata;

   logic                          back_en, back_v, out_full;
   logic [pnd_pkg::DENSITY_W-1:0] back_density;
   logic                          back_err;
   logic [OUT_W-1:0]              out_rdata;

   assign front_en = !mid_full;
   assign req_full = !front_en;

   pnd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (front_en),
      .in_valid  (req_push && !req_full),
      .sample    (req_sample),
      .mean      (mean_ff),
      .std_dev   (std_dev_ff),
      .out_valid (front_v),
      .out_item  (front_item)
   );

   pnd_fifo #(
      .W     (ITEM_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_q (
      .clock (clock),
      .reset (reset),
      .push  (front_en && front_v),
      .wdata (front_item),
      .full  (mid_full),
      .pop   (back_en && !mid_empty),
      .rdata (mid_rdata),
      .empty (mid_empty)
   );

   // Back part: advance while the output queue has room
   assign back_en = !out_full;

   pnd_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .en          (back_en),
      .in_valid    (!mid_empty),
      .in_item     (pnd_pkg::item_type'(mid_rdata)),
      .out_valid   (back_v),
      .density     (back_density),
      .sigma_error (back_err)
   );

   pnd_fifo #(
      .W     (OUT_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (back_en && back_v),
      .wdata ({back_density, back_err}),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (out_rdata),
      .empty (rsp_empty)
   );

   assign rsp_density     = out_rdata[OUT_W-1:1];
   assign rsp_sigma_error = out_rdata[0];

endmodule

`default_nettype wire

// ----- rtl/pnd_sva.sv -----
// Port-level checker for the normal density evaluator, with its bind.
`default_nettype none

module pnd_sva (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_full,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [23:0] rsp_density,
   input wire logic        rsp_sigma_error
);

   // A zero-sigma transaction always carries density 0
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_sigma_error) |-> (rsp_density == 24'd0))
      else $error("sigma error with nonzero density");

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_density)
                                    && $stable(rsp_sigma_error)))
      else $error("stalled result changed");

   // Reset empties the result queue
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("result present right after reset");

   // Reset leaves the input side open
   a_reset_open: assert property (@(posedge clock)
      $past(reset) |-> !req_full)
      else $error("input full right after reset");

endmodule

bind normal_pdf_evaluator pnd_sva u_pnd_sva (.*);

`default_nettype wire
